// ===== hw/rtl/biou_pkg.sv =====
// ----------------------------------------------------------------------------
// biou_pkg
// Shared constants and types for the box intersection-over-union block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package biou_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 12;
   localparam int unsigned FRAC_BITS_DEFAULT  = 16;

   // entries in the queue between the geometry front and the divider
   localparam int unsigned QUEUE_DEPTH = 4;

   // register stages in the geometry front
   localparam int unsigned FRONT_STAGES = 4;

   typedef struct packed {
      logic sep;    // boxes separated on an axis
      logic degen;  // union area is zero
   } biou_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/biou_front.sv =====
// ----------------------------------------------------------------------------
// biou_front
// Four-stage geometry pipeline: far edges, separation test, overlap extents,
// areas and union. Emits one record per accepted pair, never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biou_front #(
   parameter int unsigned COORD_BITS = biou_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [COORD_BITS-1:0]   a_x,
   input  wire logic [COORD_BITS-1:0]   a_y,
   input  wire logic [COORD_BITS-1:0]   a_w,
   input  wire logic [COORD_BITS-1:0]   a_h,
   input  wire logic [COORD_BITS-1:0]   b_x,
   input  wire logic [COORD_BITS-1:0]   b_y,
   input  wire logic [COORD_BITS-1:0]   b_w,
   input  wire logic [COORD_BITS-1:0]   b_h,
   output logic                         out_valid,
   output logic [2*COORD_BITS-1:0]      out_inter,
   output logic [2*COORD_BITS:0]        out_uni,
   output biou_pkg::biou_flags_type     out_flags
);

   localparam int unsigned C  = COORD_BITS;
   localparam int unsigned C1 = COORD_BITS + 1;
   localparam int unsigned A  = 2 * COORD_BITS;

   // stage 1: corners and far edges
   logic          s1_valid_ff;
   logic [C-1:0]  s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic [C-1:0]  s1_aw_ff, s1_ah_ff, s1_bw_ff, s1_bh_ff;
   logic [C1-1:0] s1_ax1_ff, s1_ay1_ff, s1_bx1_ff, s1_by1_ff;

   // stage 2: separation and overlap extents
   logic          s2_valid_ff;
   logic          s2_sep_ff;
   logic [C-1:0]  s2_ix_ff, s2_iy_ff;
   logic [C-1:0]  s2_aw_ff, s2_ah_ff, s2_bw_ff, s2_bh_ff;

   // stage 3: products
   logic          s3_valid_ff;
   logic          s3_sep_ff;
   logic [A-1:0]  s3_inter_ff, s3_area_a_ff, s3_area_b_ff;

   // stage 4: union
   logic          s4_valid_ff;
   logic          s4_sep_ff;
   logic          s4_degen_ff;
   logic [A-1:0]  s4_inter_ff;
   logic [A:0]    s4_uni_ff;

   logic          sep_in;
   logic [C1-1:0] lo_x, lo_y, hi_x, hi_y, dx, dy;
   logic [A:0]    uni_in;

   always_comb begin
      sep_in = ({1'b0, s1_ay_ff} > s1_by1_ff) || ({1'b0, s1_ax_ff} > s1_bx1_ff) ||
               (s1_ay1_ff < {1'b0, s1_by_ff}) || (s1_ax1_ff < {1'b0, s1_bx_ff});
      hi_x = (s1_ax1_ff < s1_bx1_ff) ? s1_ax1_ff : s1_bx1_ff;
      hi_y = (s1_ay1_ff < s1_by1_ff) ? s1_ay1_ff : s1_by1_ff;
      lo_x = (s1_ax_ff > s1_bx_ff) ? {1'b0, s1_ax_ff} : {1'b0, s1_bx_ff};
      lo_y = (s1_ay_ff > s1_by_ff) ? {1'b0, s1_ay_ff} : {1'b0, s1_by_ff};
      // overlap never exceeds either size when not separated, so C bits suffice
      dx = hi_x - lo_x;
      dy = hi_y - lo_y;
      uni_in = {1'b0, s3_area_a_ff} + {1'b0, s3_area_b_ff} - {1'b0, s3_inter_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ax_ff  <= a_x;
      s1_ay_ff  <= a_y;
      s1_bx_ff  <= b_x;
      s1_by_ff  <= b_y;
      s1_aw_ff  <= a_w;
      s1_ah_ff  <= a_h;
      s1_bw_ff  <= b_w;
      s1_bh_ff  <= b_h;
      s1_ax1_ff <= {1'b0, a_x} + {1'b0, a_w};
      s1_ay1_ff <= {1'b0, a_y} + {1'b0, a_h};
      s1_bx1_ff <= {1'b0, b_x} + {1'b0, b_w};
      s1_by1_ff <= {1'b0, b_y} + {1'b0, b_h};

      s2_sep_ff <= sep_in;
      s2_ix_ff  <= dx[C-1:0];
      s2_iy_ff  <= dy[C-1:0];
      s2_aw_ff  <= s1_aw_ff;
      s2_ah_ff  <= s1_ah_ff;
      s2_bw_ff  <= s1_bw_ff;
      s2_bh_ff  <= s1_bh_ff;

      s3_sep_ff    <= s2_sep_ff;
      s3_inter_ff  <= {{C{1'b0}}, s2_ix_ff} * {{C{1'b0}}, s2_iy_ff};
      s3_area_a_ff <= {{C{1'b0}}, s2_aw_ff} * {{C{1'b0}}, s2_ah_ff};
      s3_area_b_ff <= {{C{1'b0}}, s2_bw_ff} * {{C{1'b0}}, s2_bh_ff};

      s4_sep_ff   <= s3_sep_ff;
      s4_inter_ff <= s3_inter_ff;
      s4_uni_ff   <= uni_in;
      s4_degen_ff <= !s3_sep_ff && (uni_in == '0);
   end

   assign out_valid       = s4_valid_ff;
   assign out_inter       = s4_inter_ff;
   assign out_uni         = s4_uni_ff;
   assign out_flags.sep   = s4_sep_ff;
   assign out_flags.degen = s4_degen_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/biou_queue.sv =====
// ----------------------------------------------------------------------------
// biou_queue
// Short FIFO between the geometry front and the divider back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biou_queue #(
   parameter int unsigned COORD_BITS = biou_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [2*COORD_BITS-1:0]  push_inter,
   input  wire logic [2*COORD_BITS:0]    push_uni,
   input  wire biou_pkg::biou_flags_type push_flags,
   input  wire logic                     pop,
   output logic                          not_empty,
   output logic [2*COORD_BITS-1:0]       pop_inter,
   output logic [2*COORD_BITS:0]         pop_uni,
   output biou_pkg::biou_flags_type      pop_flags
);

   localparam int unsigned DEPTH = biou_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned A     = 2 * COORD_BITS;

   logic [A-1:0]             inter_mem [0:DEPTH-1];
   logic [A:0]               uni_mem   [0:DEPTH-1];
   biou_pkg::biou_flags_type flags_mem [0:DEPTH-1];

   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wptr_in  = push ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + PW'(1) : rptr_ff;
      count_in = count_ff;
      priority if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         inter_mem[wptr_ff] <= push_inter;
         uni_mem[wptr_ff]   <= push_uni;
         flags_mem[wptr_ff] <= push_flags;
      end
   end

   assign not_empty = (count_ff != '0);
   assign pop_inter = inter_mem[rptr_ff];
   assign pop_uni   = uni_mem[rptr_ff];
   assign pop_flags = flags_mem[rptr_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(DEPTH)) |-> !push)
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/biou_div.sv =====
// ----------------------------------------------------------------------------
// biou_div
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1
// stages, computes floor(inter * 2^FRAC_BITS / union). Never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biou_div #(
   parameter int unsigned COORD_BITS = biou_pkg::COORD_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = biou_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [2*COORD_BITS-1:0]  in_inter,
   input  wire logic [2*COORD_BITS:0]    in_uni,
   input  wire biou_pkg::biou_flags_type in_flags,
   output logic                          out_valid,
   output logic [FRAC_BITS:0]            out_ratio,
   output logic                          out_degen
);

   localparam int unsigned STEPS = FRAC_BITS + 1;
   localparam int unsigned RW    = 2 * COORD_BITS + 2;
   localparam int unsigned DW    = 2 * COORD_BITS + 1;

   logic                     valid_ff [0:STEPS];
   logic [RW-1:0]            rem_ff   [0:STEPS];
   logic [DW-1:0]            den_ff   [0:STEPS];
   logic [STEPS-1:0]         quo_ff   [0:STEPS];
   biou_pkg::biou_flags_type flags_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]   <= {2'b00, in_inter};
      den_ff[0]   <= in_uni;
      quo_ff[0]   <= '0;
      flags_ff[0] <= in_flags;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [RW-1:0] shifted;
      logic          qbit;
      logic [RW-1:0] rem_in;

      always_comb begin
         // first step takes the integer bit without a shift
         shifted = (j == 0) ? rem_ff[j] : {rem_ff[j][RW-2:0], 1'b0};
         qbit    = (shifted >= {1'b0, den_ff[j]});
         rem_in  = qbit ? (shifted - {1'b0, den_ff[j]}) : shifted;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j+1]   <= rem_in;
         den_ff[j+1]   <= den_ff[j];
         quo_ff[j+1]   <= {quo_ff[j][STEPS-2:0], qbit};
         flags_ff[j+1] <= flags_ff[j];
      end
   end

   // overlap never exceeds the union, so the quotient stays at or below one
   assign out_valid = valid_ff[STEPS];
   assign out_ratio = (flags_ff[STEPS].sep || flags_ff[STEPS].degen) ? '0 : quo_ff[STEPS];
   assign out_degen = flags_ff[STEPS].degen;

endmodule

`default_nettype wire

// ===== hw/rtl/box_iou.sv =====
// ----------------------------------------------------------------------------
// box_iou
// Intersection over union of two axis-aligned boxes, 16-bit fraction result.
// ----------------------------------------------------------------------------
// One box pair can be taken every clock while busy is low; a transfer happens
// at an edge with start high and busy low. Each result is driven on rsp_ratio
// and rsp_degenerate with rsp_valid high for exactly one cycle and is taken in
// order, after the pair passes the four geometry stages, the queue, then the
// divider input register and FRAC_BITS + 1 stages retiring one quotient bit
// each. The receiver cannot stall, so the back end drains every cycle and busy
// stays low in normal streaming; it only guards the front pipeline and queue
// against overfill.
`timescale 1ns / 1ps
`default_nettype none

module box_iou #(
   parameter int unsigned COORD_BITS = biou_pkg::COORD_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = biou_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_BITS-1:0] req_a_x,
   input  wire logic [COORD_BITS-1:0] req_a_y,
   input  wire logic [COORD_BITS-1:0] req_a_w,
   input  wire logic [COORD_BITS-1:0] req_a_h,
   input  wire logic [COORD_BITS-1:0] req_b_x,
   input  wire logic [COORD_BITS-1:0] req_b_y,
   input  wire logic [COORD_BITS-1:0] req_b_w,
   input  wire logic [COORD_BITS-1:0] req_b_h,
   output logic                       rsp_valid,
   output logic [FRAC_BITS:0]         rsp_ratio,
   output logic                       rsp_degenerate
);

   localparam int unsigned LIMIT = biou_pkg::QUEUE_DEPTH + biou_pkg::FRONT_STAGES;
   localparam int unsigned OW    = $clog2(LIMIT + 1);
   localparam int unsigned A     = 2 * COORD_BITS;

   logic accept;

   logic                     f_valid;
   logic [A-1:0]             f_inter;
   logic [A:0]               f_uni;
   biou_pkg::biou_flags_type f_flags;

   logic                     q_not_empty;
   logic [A-1:0]             q_inter;
   logic [A:0]               q_uni;
   biou_pkg::biou_flags_type q_flags;

   // pairs in the front pipeline plus pairs waiting in the queue
   logic [OW-1:0] occ_ff, occ_in;

   assign busy   = (occ_ff == OW'(LIMIT));
   assign accept = start && !busy;

   always_comb begin
      occ_in = occ_ff;
      priority if (accept && !q_not_empty) begin
         occ_in = occ_ff + OW'(1);
      end else if (q_not_empty && !accept) begin
         occ_in = occ_ff - OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   biou_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_w       (req_a_w),
      .a_h       (req_a_h),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .b_w       (req_b_w),
      .b_h       (req_b_h),
      .out_valid (f_valid),
      .out_inter (f_inter),
      .out_uni   (f_uni),
      .out_flags (f_flags)
   );

   biou_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_inter (f_inter),
      .push_uni   (f_uni),
      .push_flags (f_flags),
      .pop        (q_not_empty),
      .not_empty  (q_not_empty),
      .pop_inter  (q_inter),
      .pop_uni    (q_uni),
      .pop_flags  (q_flags)
   );

   biou_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_inter  (q_inter),
      .in_uni    (q_uni),
      .in_flags  (q_flags),
      .out_valid (rsp_valid),
      .out_ratio (rsp_ratio),
      .out_degen (rsp_degenerate)
   );

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(LIMIT))
      else $error("occupancy exceeds front and queue capacity");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_ratio == '0))
      else $error("degenerate result with nonzero ratio");

   a_ratio_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ratio <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
      else $error("ratio above one");

   a_idle_busy: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> !busy)
      else $error("busy while empty");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_box_iou.sv =====
// ----------------------------------------------------------------------------
// tb_box_iou
// Self-checking bench for the box intersection-over-union block.
// ----------------------------------------------------------------------------
// Box pairs go in through the start/busy command port with random gaps. Each
// accepted pair is scored by a local IoU calculator using exact integer math,
// and the result is queued. A monitor pops the queue on every rsp_valid
// strobe and compares ratio and degenerate flag. Directed corner and edge
// cases run first, then mostly-overlapping random pairs mixed with fully
// random ones. Midway the sender stops until every pending result is back.
`timescale 1ns / 1ps

module tb_box_iou;

   localparam int unsigned CB           = biou_pkg::COORD_BITS_DEFAULT;
   localparam int unsigned FB           = biou_pkg::FRAC_BITS_DEFAULT;
   localparam int unsigned LATENCY      = FB + 7;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_PAIRS = 800;
   localparam int unsigned MAX_PRINTS   = 40;

   typedef logic [CB-1:0] coord_type;

   typedef struct {
      coord_type ax, ay, aw, ah;
      coord_type bx, by, bw, bh;
   } box_pair_type;

   typedef struct {
      logic [FB:0] ratio;
      logic        degen;
   } iou_result_type;

   typedef struct {
      box_pair_type   pair;
      iou_result_type res;
   } iou_pending_type;

   typedef enum int {
      PAIR_NEAR,
      PAIR_SMALL,
      PAIR_ANY,
      PAIR_FLAT
   } pair_kind_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_a_x = '0, req_a_y = '0, req_a_w = '0, req_a_h = '0;
   coord_type req_b_x = '0, req_b_y = '0, req_b_w = '0, req_b_h = '0;
   logic        rsp_valid;
   logic [FB:0] rsp_ratio;
   logic        rsp_degenerate;

   iou_pending_type iou_expected[$];

   int unsigned mismatch_count = 0;
   int unsigned pairs_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned degen_seen     = 0;
   int unsigned full_seen      = 0;
   int unsigned zero_seen      = 0;
   int unsigned cycle_count    = 0;
   bit          burst_mode     = 1'b0;

   box_iou #(
      .COORD_BITS(CB),
      .FRAC_BITS (FB)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_w       (req_a_w),
      .req_a_h       (req_a_h),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_w       (req_b_w),
      .req_b_h       (req_b_h),
      .rsp_valid     (rsp_valid),
      .rsp_ratio     (rsp_ratio),
      .rsp_degenerate(rsp_degenerate)
   );

   always #10 clock = ~clock;

   // exact IoU: strict separation test first, then overlap / union in 64 bits
   function automatic iou_result_type predict_iou(input box_pair_type p);
      longint unsigned ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint unsigned ix, iy, overlap, union_area, q;
      iou_result_type r;
      ax0 = 64'(p.ax);  ay0 = 64'(p.ay);  ax1 = ax0 + 64'(p.aw);  ay1 = ay0 + 64'(p.ah);
      bx0 = 64'(p.bx);  by0 = 64'(p.by);  bx1 = bx0 + 64'(p.bw);  by1 = by0 + 64'(p.bh);
      r.ratio = '0;
      r.degen = 1'b0;
      if (!(ay0 > by1 || ax0 > bx1 || ay1 < by0 || ax1 < bx0)) begin
         ix = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
         iy = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
         overlap = ix * iy;
         union_area = 64'(p.aw) * 64'(p.ah) + 64'(p.bw) * 64'(p.bh) - overlap;
         if (union_area == 0) begin
            r.degen = 1'b1;
         end else begin
            q = (overlap << FB) / union_area;
            if (q > (64'd1 << FB)) q = 64'd1 << FB;
            r.ratio = q[FB:0];
         end
      end
      return r;
   endfunction

   function automatic box_pair_type make_pair(input int unsigned ax, ay, aw, ah,
                                              input int unsigned bx, by, bw, bh);
      box_pair_type p;
      p.ax = coord_type'(ax);  p.ay = coord_type'(ay);
      p.aw = coord_type'(aw);  p.ah = coord_type'(ah);
      p.bx = coord_type'(bx);  p.by = coord_type'(by);
      p.bw = coord_type'(bw);  p.bh = coord_type'(bh);
      return p;
   endfunction

   function automatic coord_type rand_size();
      if ($urandom_range(0, 3) == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 255));
   endfunction

   function automatic box_pair_type rand_pair(input pair_kind_type kind);
      box_pair_type p;
      p.ax = coord_type'($urandom);  p.ay = coord_type'($urandom);
      p.aw = rand_size();  p.ah = rand_size();
      case (kind)
         PAIR_NEAR, PAIR_FLAT: begin
            // second box anchored inside or just before the first one
            p.bx = p.ax + coord_type'($urandom_range(0, p.aw))
                        - coord_type'($urandom_range(0, 64));
            p.by = p.ay + coord_type'($urandom_range(0, p.ah))
                        - coord_type'($urandom_range(0, 64));
            p.bw = rand_size();  p.bh = rand_size();
            if ($urandom_range(0, 15) == 0) begin
               p.bx = p.ax;  p.by = p.ay;  p.bw = p.aw;  p.bh = p.ah;
            end
            if (kind == PAIR_FLAT) begin
               if ($urandom_range(0, 1)) p.aw = '0; else p.ah = '0;
               if ($urandom_range(0, 1)) p.bw = '0;
               if ($urandom_range(0, 1)) p.bh = '0;
            end
         end
         PAIR_SMALL: begin
            p.ax = coord_type'($urandom_range(0, 63));
            p.ay = coord_type'($urandom_range(0, 63));
            p.aw = coord_type'($urandom_range(0, 31));
            p.ah = coord_type'($urandom_range(0, 31));
            p.bx = coord_type'($urandom_range(0, 63));
            p.by = coord_type'($urandom_range(0, 63));
            p.bw = coord_type'($urandom_range(0, 31));
            p.bh = coord_type'($urandom_range(0, 31));
         end
         default: begin
            p.aw = coord_type'($urandom);  p.ah = coord_type'($urandom);
            p.bx = coord_type'($urandom);  p.by = coord_type'($urandom);
            p.bw = coord_type'($urandom);  p.bh = coord_type'($urandom);
         end
      endcase
      return p;
   endfunction

   function automatic int unsigned pick_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 4);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // inputs change on the falling edge; the transfer is taken at the rising
   // edge where start is high and busy is low
   task automatic send_pair(input box_pair_type p, input int unsigned gap);
      iou_pending_type e;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start   <= 1'b1;
      req_a_x <= p.ax;  req_a_y <= p.ay;  req_a_w <= p.aw;  req_a_h <= p.ah;
      req_b_x <= p.bx;  req_b_y <= p.by;  req_b_w <= p.bw;  req_b_h <= p.bh;
      @(posedge clock);
      while (busy) @(posedge clock);
      e.pair = p;
      e.res  = predict_iou(p);
      iou_expected.push_back(e);
      pairs_sent++;
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      start <= 1'b0;
      while (iou_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_boxes();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
      send_pair(make_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095), pick_gap());
      send_pair(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
      send_pair(make_pair(0, 0, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
      send_pair(make_pair(0, 0, 4095, 4095, 4095, 4095, 0, 0), pick_gap());
      send_pair(make_pair(4095, 0, 0, 4095, 0, 4095, 4095, 0), pick_gap());
      send_pair(make_pair(0, 0, 1, 1, 0, 0, 4095, 4095), pick_gap());
      send_pair(make_pair(100, 100, 100, 100, 110, 110, 10, 10), pick_gap());
      send_pair(make_pair(0, 0, 10, 10, 5, 0, 10, 10), pick_gap());
      send_pair(make_pair(2730, 1365, 1365, 2730, 1365, 2730, 2730, 1365), pick_gap());
   endtask

   task automatic test_special_cases();
      // separated on x, then on y, then on both
      send_pair(make_pair(0, 0, 10, 10, 11, 0, 10, 10), pick_gap());
      send_pair(make_pair(0, 20, 10, 10, 0, 0, 10, 19), pick_gap());
      send_pair(make_pair(50, 50, 5, 5, 0, 0, 10, 10), pick_gap());
      // shared edge or corner: not separated, overlap zero
      send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10), pick_gap());
      send_pair(make_pair(0, 0, 10, 10, 10, 10, 10, 10), pick_gap());
      // zero-area boxes that still meet: zero union
      send_pair(make_pair(7, 7, 0, 0, 7, 7, 0, 0), pick_gap());
      send_pair(make_pair(0, 0, 0, 5, 0, 3, 0, 9), pick_gap());
      send_pair(make_pair(0, 0, 8, 0, 8, 0, 4, 0), pick_gap());
      // zero-area boxes that are apart
      send_pair(make_pair(0, 0, 0, 0, 5, 0, 0, 0), pick_gap());
      // point inside a box, line across a box
      send_pair(make_pair(5, 5, 0, 0, 0, 0, 10, 10), pick_gap());
      send_pair(make_pair(0, 5, 20, 0, 5, 0, 10, 10), pick_gap());
   endtask

   task automatic test_random_pairs(input int unsigned count);
      int unsigned   sel;
      pair_kind_type kind;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         sel = $urandom_range(0, 9);
         if (sel < 5)      kind = PAIR_NEAR;
         else if (sel < 7) kind = PAIR_SMALL;
         else if (sel < 9) kind = PAIR_ANY;
         else              kind = PAIR_FLAT;
         send_pair(rand_pair(kind), pick_gap());
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_drain_and_resume();
      wait_results_done();
      test_random_pairs(RANDOM_PAIRS / 2);
   endtask

   // result monitor: one expectation per strobe, oldest first
   always @(posedge clock) begin
      iou_pending_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (iou_expected.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: ratio=%0d degen=%0b",
                                      rsp_ratio, rsp_degenerate));
         end else begin
            e = iou_expected.pop_front();
            if (rsp_ratio !== e.res.ratio)
               report_mismatch($sformatf({"ratio %0d, want %0d ",
                  "(a=%0d,%0d,%0d,%0d b=%0d,%0d,%0d,%0d)"},
                  rsp_ratio, e.res.ratio, e.pair.ax, e.pair.ay, e.pair.aw, e.pair.ah,
                  e.pair.bx, e.pair.by, e.pair.bw, e.pair.bh));
            if (rsp_degenerate !== e.res.degen)
               report_mismatch($sformatf({"degenerate %0b, want %0b ",
                  "(a=%0d,%0d,%0d,%0d b=%0d,%0d,%0d,%0d)"},
                  rsp_degenerate, e.res.degen, e.pair.ax, e.pair.ay, e.pair.aw, e.pair.ah,
                  e.pair.bx, e.pair.by, e.pair.bw, e.pair.bh));
            if (e.res.degen) degen_seen++;
            if (e.res.ratio == {1'b1, {FB{1'b0}}}) full_seen++;
            if (e.res.ratio == '0 && !e.res.degen) zero_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, iou_expected.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_boxes();
      test_special_cases();
      test_random_pairs(RANDOM_PAIRS / 2);
      test_drain_and_resume();

      wait_results_done();
      repeat (LATENCY + 8) @(posedge clock);

      $display("covered %0d box pairs, %0d results checked in %0d cycles",
               pairs_sent, results_seen, cycle_count);
      $display("full overlap %0d, zero ratio %0d, zero union %0d, mismatches %0d",
               full_seen, zero_seen, degen_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/biou_pkg.sv
hw/rtl/biou_front.sv
hw/rtl/biou_queue.sv
hw/rtl/biou_div.sv
hw/rtl/box_iou.sv
tb/tb_box_iou.sv
